[hdl/assert_macros.svh]
// assertion macros for the rtl, included by bcam_bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

[hdl/bcam_pkg.sv]
// types, constants and helpers of the bank controller address map
package bcam_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int OFFS_W = 14;
    localparam int ROMB_W = 7;
    localparam int RAMB_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [3:0] {
        REG_ROM0    = 4'd0,
        REG_ROMBANK = 4'd1,
        REG_VRAM    = 4'd2,
        REG_EXTRAM  = 4'd3,
        REG_WRAM    = 4'd4,
        REG_ECHO    = 4'd5,
        REG_OAM     = 4'd6,
        REG_GAP0    = 4'd7,
        REG_IO      = 4'd8,
        REG_GAP1    = 4'd9,
        REG_HRAM    = 4'd10,
        REG_IE      = 4'd11
    } region_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_MBC1  = 2'd1,
        KIND_MBC3  = 2'd2,
        KIND_OTHER = 2'd3
    } ctrl_kind_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // register indexes on the apb port
    localparam logic [0:0] CFG_KIND        = 1'b0;
    localparam logic [0:0] CFG_RAM_PRESENT = 1'b1;

    // upper limits of the regions
    localparam logic [ADDR_W-1:0] TOP_ROM0    = 16'h4000;
    localparam logic [ADDR_W-1:0] TOP_ROMBANK = 16'h8000;
    localparam logic [ADDR_W-1:0] TOP_VRAM    = 16'hA000;
    localparam logic [ADDR_W-1:0] TOP_EXTRAM  = 16'hC000;
    localparam logic [ADDR_W-1:0] TOP_WRAM    = 16'hE000;
    localparam logic [ADDR_W-1:0] TOP_ECHO    = 16'hFE00;
    localparam logic [ADDR_W-1:0] TOP_OAM     = 16'hFEA0;
    localparam logic [ADDR_W-1:0] TOP_GAP0    = 16'hFF00;
    localparam logic [ADDR_W-1:0] TOP_IO      = 16'hFF4C;
    localparam logic [ADDR_W-1:0] TOP_GAP1    = 16'hFF80;
    localparam logic [ADDR_W-1:0] TOP_HRAM    = 16'hFFFF;

    // bank controller write windows
    localparam logic [ADDR_W-1:0] BANK_ROMSEL = 16'h2000;
    localparam logic [ADDR_W-1:0] BANK_HISEL  = 16'h4000;
    localparam logic [ADDR_W-1:0] BANK_MODE   = 16'h6000;

    typedef struct packed {
        region_t           region;
        logic [OFFS_W-1:0] offset;
        logic              store_access;
    } dec_t;

    typedef struct packed {
        logic [ROMB_W-1:0] rom_bank;
        logic [RAMB_W-1:0] ram_bank;
        logic              controller_fault;
    } bank_t;

    function automatic logic [ADDR_W-1:0] region_base(input region_t r);
        logic [ADDR_W-1:0] b;
        unique case (r)
            REG_ROM0:    b = 16'h0000;
            REG_ROMBANK: b = TOP_ROM0;
            REG_VRAM:    b = TOP_ROMBANK;
            REG_EXTRAM:  b = TOP_VRAM;
            REG_WRAM:    b = TOP_EXTRAM;
            REG_ECHO:    b = TOP_WRAM;
            REG_OAM:     b = TOP_ECHO;
            REG_GAP0:    b = TOP_OAM;
            REG_IO:      b = TOP_GAP0;
            REG_GAP1:    b = TOP_IO;
            REG_HRAM:    b = TOP_GAP1;
            REG_IE:      b = TOP_HRAM;
            default:     b = 16'h0000;
        endcase
        return b;
    endfunction

endpackage

[hdl/bcam_decode.sv]
// address decoder: region, offset and store access flag
module bcam_decode
(
    input  logic                            is_write,
    input  logic [bcam_pkg::ADDR_W-1:0]     address,
    input  logic                            ram_present,
    output bcam_pkg::dec_t                  dec
);

    bcam_pkg::region_t           region;
    logic [bcam_pkg::ADDR_W-1:0] diff;

    always_comb
    begin
        priority if (address < bcam_pkg::TOP_ROM0)    region = bcam_pkg::REG_ROM0;
        else if (address < bcam_pkg::TOP_ROMBANK)     region = bcam_pkg::REG_ROMBANK;
        else if (address < bcam_pkg::TOP_VRAM)        region = bcam_pkg::REG_VRAM;
        else if (address < bcam_pkg::TOP_EXTRAM)      region = bcam_pkg::REG_EXTRAM;
        else if (address < bcam_pkg::TOP_WRAM)        region = bcam_pkg::REG_WRAM;
        else if (address < bcam_pkg::TOP_ECHO)        region = bcam_pkg::REG_ECHO;
        else if (address < bcam_pkg::TOP_OAM)         region = bcam_pkg::REG_OAM;
        else if (address < bcam_pkg::TOP_GAP0)        region = bcam_pkg::REG_GAP0;
        else if (address < bcam_pkg::TOP_IO)          region = bcam_pkg::REG_IO;
        else if (address < bcam_pkg::TOP_GAP1)        region = bcam_pkg::REG_GAP1;
        else if (address < bcam_pkg::TOP_HRAM)        region = bcam_pkg::REG_HRAM;
        else                                          region = bcam_pkg::REG_IE;
    end

    assign diff = address - bcam_pkg::region_base(region);

    always_comb
    begin
        dec.region       = region;
        dec.offset       = diff[bcam_pkg::OFFS_W-1:0];
        dec.store_access = 1'b1;
        if (region == bcam_pkg::REG_GAP0 || region == bcam_pkg::REG_GAP1)
        begin
            dec.store_access = 1'b0;
        end
        if (region == bcam_pkg::REG_EXTRAM && !ram_present)
        begin
            dec.store_access = 1'b0;
        end
        // writes into the rom area only go to the bank controller
        if (is_write && (region == bcam_pkg::REG_ROM0 || region == bcam_pkg::REG_ROMBANK))
        begin
            dec.store_access = 1'b0;
        end
    end

endmodule

[hdl/bcam_bank.sv]
// bank controller state: mode bit, rom and ram select
`include "assert_macros.svh"

module bcam_bank
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            is_write,
    input  logic [bcam_pkg::ADDR_W-1:0]     address,
    input  logic [bcam_pkg::DATA_W-1:0]     write_data,
    input  bcam_pkg::ctrl_kind_t            kind,
    output bcam_pkg::bank_t                 bank
);

    logic                          mode_reg;
    logic                          mode_next;
    logic [bcam_pkg::ROMB_W-1:0]   rom_sel_reg;
    logic [bcam_pkg::ROMB_W-1:0]   rom_sel_next;
    logic [bcam_pkg::RAMB_W-1:0]   ram_sel_reg;
    logic [bcam_pkg::RAMB_W-1:0]   ram_sel_next;
    logic                          bank_wr;
    logic                          fault;

    assign bank_wr = is_write && (address < bcam_pkg::TOP_ROMBANK);

    always_comb
    begin
        mode_next    = mode_reg;
        rom_sel_next = rom_sel_reg;
        ram_sel_next = ram_sel_reg;
        fault        = 1'b0;
        if (bank_wr)
        begin
            priority if (kind == bcam_pkg::KIND_NONE)
            begin
                mode_next = mode_reg;
            end
            else if (address >= bcam_pkg::BANK_MODE)
            begin
                mode_next = write_data[0];
            end
            else if (kind == bcam_pkg::KIND_OTHER)
            begin
                fault = 1'b1;
            end
            else if (address >= bcam_pkg::BANK_HISEL)
            begin
                if (kind == bcam_pkg::KIND_MBC1 && !mode_reg)
                begin
                    rom_sel_next = {write_data[1:0], rom_sel_reg[4:0]};
                end
                else
                begin
                    ram_sel_next = write_data[bcam_pkg::RAMB_W-1:0];
                end
            end
            else if (address >= bcam_pkg::BANK_ROMSEL)
            begin
                if (kind == bcam_pkg::KIND_MBC1)
                begin
                    rom_sel_next = {rom_sel_reg[6:5], write_data[4:0]};
                end
                else if (write_data[bcam_pkg::ROMB_W-1:0] == '0)
                begin
                    rom_sel_next = bcam_pkg::ROMB_W'(1);
                end
                else
                begin
                    rom_sel_next = write_data[bcam_pkg::ROMB_W-1:0];
                end
            end
            else
            begin
                // ram enable window: ignored
                mode_next = mode_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            rom_sel_reg <= bcam_pkg::ROMB_W'(1);
            ram_sel_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            rom_sel_reg <= rom_sel_next;
            ram_sel_reg <= ram_sel_next;
        end
    end

    // banks as seen after this access, zero select maps to one
    always_comb
    begin
        bank.rom_bank         = (rom_sel_next == '0) ? bcam_pkg::ROMB_W'(1) : rom_sel_next;
        bank.ram_bank         = ram_sel_next;
        bank.controller_fault = fault;
    end

    `ASSERT_CLK(a_fault_only_other, fault |-> (kind == bcam_pkg::KIND_OTHER && bank_wr))
    `ASSERT_NEVER(a_rom_bank_zero, bank.rom_bank == '0)
    `ASSERT_CLK(a_hold_when_idle,
        !advance |=> ($stable(rom_sel_reg) && $stable(ram_sel_reg) && $stable(mode_reg)))
    `ASSERT_CLK(a_none_kind_frozen, (advance && kind == bcam_pkg::KIND_NONE)
        |=> ($stable(rom_sel_reg) && $stable(ram_sel_reg) && $stable(mode_reg)))

endmodule

[hdl/bank_controller_address_map.sv]
// top level of the bank controller address map
// usage:
//   input stream s_*: one bus access per word. s_tdata holds address and
//   write data, s_tuser the access kind (read or write).
//   output stream m_*: one result word per access, in order.
//   apb port: register 0 controller kind at 0x0, register 1 ram present at 0x4.
//   write configuration only while no access is in flight.
// timing:
//   two register stages (input register, result register); the result register
//   drives m_tvalid. one access per cycle sustained while m_tready is high; the bank
//   update is a single pass of decode logic between the two stages.
// reset:
//   rst_n clears both stages, the configuration (kind none, no ram) and the
//   bank state (rom bank 1, ram bank 0, rom banking mode).
// stall:
//   when m_tready is low the result word holds, the input register still
//   fills once, then s_tready drops until the result is taken.
module bank_controller_address_map
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] address, [23:16] write_data
    input  logic [bcam_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] opcode
    input  logic                              s_tuser,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] region, [17:4] offset, [24:18] rom_bank, [26:25] ram_bank,
    // [27] store_access, [28] controller_fault, [31:29] zero
    output logic [bcam_pkg::M_TDATA_W-1:0]    m_tdata,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bcam_pkg::PADDR_W-1:0]      paddr,
    input  logic [bcam_pkg::PDATA_W-1:0]      pwdata,
    output logic [bcam_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic                           s1_valid_reg;
    logic                           s1_write_reg;
    logic [bcam_pkg::ADDR_W-1:0]    s1_addr_reg;
    logic [bcam_pkg::DATA_W-1:0]    s1_data_reg;
    logic                           m_valid_reg;
    logic [bcam_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [bcam_pkg::M_TDATA_W-1:0] m_data_next;
    bcam_pkg::ctrl_kind_t           kind_reg;
    logic                           ram_present_reg;
    logic                           out_free;
    logic                           advance;
    logic                           cfg_wr;
    logic [0:0]                     cfg_idx;
    bcam_pkg::dec_t                 dec;
    bcam_pkg::bank_t                bank;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_write_reg <= s_tuser;
            s1_addr_reg  <= s_tdata[bcam_pkg::ADDR_W-1:0];
            s1_data_reg  <= s_tdata[bcam_pkg::ADDR_W +: bcam_pkg::DATA_W];
        end
    end

    bcam_decode u_decode
    (
        .is_write    (s1_write_reg == bcam_pkg::OP_WRITE),
        .address     (s1_addr_reg),
        .ram_present (ram_present_reg),
        .dec         (dec)
    );

    bcam_bank u_bank
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .is_write   (s1_write_reg == bcam_pkg::OP_WRITE),
        .address    (s1_addr_reg),
        .write_data (s1_data_reg),
        .kind       (kind_reg),
        .bank       (bank)
    );

    assign m_data_next = {3'b000, bank.controller_fault, dec.store_access,
                          bank.ram_bank, bank.rom_bank, dec.offset, dec.region};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_idx = paddr[bcam_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= bcam_pkg::KIND_NONE;
            ram_present_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                bcam_pkg::CFG_KIND:        kind_reg <= bcam_pkg::ctrl_kind_t'(pwdata[1:0]);
                bcam_pkg::CFG_RAM_PRESENT: ram_present_reg <= pwdata[0];
                default:                   ram_present_reg <= ram_present_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            bcam_pkg::CFG_KIND:        prdata = {30'd0, kind_reg};
            bcam_pkg::CFG_RAM_PRESENT: prdata = {31'd0, ram_present_reg};
            default:                   prdata = '0;
        endcase
    end

endmodule

[sim/bank_controller_address_map_tb.sv]
// stream testbench of the bank controller address map: directed and random bus accesses
`timescale 1ns / 100ps

module bank_controller_address_map_tb;
    import bcam_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 175;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } bus_access_t;

    typedef struct {
        region_t           region;
        logic [OFFS_W-1:0] offset;
        logic [ROMB_W-1:0] rom_bank;
        logic [RAMB_W-1:0] ram_bank;
        logic              store;
        logic              fault;
    } map_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bank_controller_address_map dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted controller state and configuration
    ctrl_kind_t        mbc_kind = KIND_NONE;
    logic              ram_fitted = 1'b0;
    logic              bank_mode = 1'b0;
    logic [ROMB_W-1:0] rom_sel = 7'd1;
    logic [RAMB_W-1:0] ram_sel = 2'd0;

    bus_access_t pending_access[$];
    map_result_t map_expect[$];
    bus_access_t next_access;
    map_result_t want;
    int          errors = 0;
    int          cyc = 0;
    int          quiet = 0;
    logic        calm;

    // idling of driver and monitor is switched off in one recurring stretch of cyc
    assign calm = (cyc % 1000) >= 760;

    function automatic int area_floor(input int idx);
        case (idx)
            0:       return 'h0000;
            1:       return 'h4000;
            2:       return 'h8000;
            3:       return 'hA000;
            4:       return 'hC000;
            5:       return 'hE000;
            6:       return 'hFE00;
            7:       return 'hFEA0;
            8:       return 'hFF00;
            9:       return 'hFF4C;
            10:      return 'hFF80;
            11:      return 'hFFFF;
            default: return 'h10000;
        endcase
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic predict_access(input op_t op, input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] data);
        map_result_t r;
        int          idx;
        idx = 0;
        while (idx < 11 && int'(addr) >= area_floor(idx + 1))
            idx++;
        r.region = region_t'(idx);
        r.offset = OFFS_W'(int'(addr) - area_floor(idx));
        r.store  = !(r.region == REG_GAP0 || r.region == REG_GAP1 ||
                     (r.region == REG_EXTRAM && !ram_fitted));
        r.fault  = 1'b0;
        if (op == OP_WRITE && idx <= 1)
        begin
            r.store = 1'b0;
            if (mbc_kind != KIND_NONE)
            begin
                if (addr >= 16'h6000)
                    bank_mode = data[0];
                else if (mbc_kind == KIND_OTHER)
                    r.fault = 1'b1;
                else if (addr >= 16'h2000 && addr < 16'h4000)
                begin
                    if (mbc_kind == KIND_MBC1)
                        rom_sel = {rom_sel[6:5], data[4:0]};
                    else
                        rom_sel = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
                end
                else if (addr >= 16'h4000)
                begin
                    // mbc1 in rom mode takes the upper two rom bits here
                    if (mbc_kind == KIND_MBC1 && !bank_mode)
                        rom_sel = {data[1:0], rom_sel[4:0]};
                    else
                        ram_sel = data[1:0];
                end
            end
        end
        r.rom_bank = (rom_sel == 7'd0) ? 7'd1 : rom_sel;
        r.ram_bank = ram_sel;
        map_expect.push_back(r);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                predict_access(op_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]);
            if (!s_tvalid || s_tready)
            begin
                if (pending_access.size() != 0 && (calm || $urandom_range(0, 99) >= 13))
                begin
                    next_access = pending_access.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_access.data, next_access.addr};
                    s_tuser  <= next_access.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (map_expect.size() == 0)
                    note_error($sformatf("unexpected result word %h", m_tdata));
                else
                begin
                    want = map_expect.pop_front();
                    if (m_tdata[3:0] !== want.region || m_tdata[17:4] !== want.offset ||
                        m_tdata[24:18] !== want.rom_bank || m_tdata[26:25] !== want.ram_bank ||
                        m_tdata[27] !== want.store || m_tdata[28] !== want.fault ||
                        m_tdata[31:29] !== 3'b000)
                        note_error($sformatf({"mismatch: expected region %0d offset %h ",
                            "rom %0d ram %0d store %b fault %b, got word %h (region %0d ",
                            "offset %h rom %0d ram %0d store %b fault %b)"},
                            want.region, want.offset, want.rom_bank, want.ram_bank,
                            want.store, want.fault, m_tdata, m_tdata[3:0], m_tdata[17:4],
                            m_tdata[24:18], m_tdata[26:25], m_tdata[27], m_tdata[28]));
                end
            end
            m_tready <= calm || $urandom_range(0, 99) >= 13;
        end
    end

    // watchdog on cycles in which no word moves
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT)
            begin
                $display("bank_controller_address_map_tb: errors");
                $finish;
            end
        end
    end

    task automatic queue_access(input op_t op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        bus_access_t a;
        a.op   = op;
        a.addr = addr;
        a.data = data;
        pending_access.push_back(a);
    endtask

    task automatic wait_drained();
        while (pending_access.size() != 0 || s_tvalid || map_expect.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // write a register, then read it back
    task automatic cfg_write(input logic [0:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == CFG_KIND)
            mbc_kind = ctrl_kind_t'(value[1:0]);
        else
            ram_fitted = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
            note_error($sformatf("register %0d read back %h, expected %h", idx, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input ctrl_kind_t k, input logic rp);
        wait_drained();
        cfg_write(CFG_KIND, PDATA_W'(k));
        cfg_write(CFG_RAM_PRESENT, PDATA_W'(rp));
    endtask

    initial
    begin
        int                pick;
        int                idx;
        int                lo;
        int                hi;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // mbc1 with ram: zero select, upper bits, mode switch, ram select
        set_config(KIND_MBC1, 1'b1);
        queue_access(OP_READ,  16'h0000, 8'h00);
        queue_access(OP_READ,  16'h3FFF, 8'hFF);
        queue_access(OP_WRITE, 16'h2000, 8'h00);
        queue_access(OP_WRITE, 16'h3FFF, 8'hFF);
        queue_access(OP_WRITE, 16'h4000, 8'h03);
        queue_access(OP_WRITE, 16'h6000, 8'h01);
        queue_access(OP_WRITE, 16'h5FFF, 8'h02);
        queue_access(OP_WRITE, 16'h1FFF, 8'h0A);
        queue_access(OP_READ,  16'h7FFF, 8'h00);
        queue_access(OP_READ,  16'hA000, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'h55);
        queue_access(OP_READ,  16'hE000, 8'h00);
        queue_access(OP_READ,  16'hFDFF, 8'h00);
        queue_access(OP_WRITE, 16'h7FFF, 8'hFE);

        // mbc3 without ram: zero and masked-zero selects become one
        set_config(KIND_MBC3, 1'b0);
        queue_access(OP_WRITE, 16'h2100, 8'h00);
        queue_access(OP_WRITE, 16'h3000, 8'h80);
        queue_access(OP_WRITE, 16'h2000, 8'h7F);
        queue_access(OP_WRITE, 16'h4000, 8'hFF);
        queue_access(OP_READ,  16'hA000, 8'h00);
        queue_access(OP_READ,  16'hFEA0, 8'h00);
        queue_access(OP_WRITE, 16'hFF4C, 8'hAB);
        queue_access(OP_READ,  16'hFFFF, 8'h00);

        // unsupported kind faults below the mode window only
        set_config(KIND_OTHER, 1'b1);
        queue_access(OP_WRITE, 16'h0000, 8'h12);
        queue_access(OP_WRITE, 16'h6000, 8'h01);
        queue_access(OP_READ,  16'hFF80, 8'h00);

        // no controller: banking writes change nothing
        set_config(KIND_NONE, 1'b0);
        queue_access(OP_WRITE, 16'h2000, 8'h05);
        queue_access(OP_READ,  16'hFE00, 8'h00);
        queue_access(OP_READ,  16'hFF00, 8'h00);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_config(ctrl_kind_t'((ph + 1) % 4), 1'(ph ^ (ph >> 2)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    op   = OP_WRITE;
                    addr = ADDR_W'($urandom_range(0, 'h7FFF));
                end
                else if (pick < 75)
                begin
                    idx = $urandom_range(0, 11);
                    lo  = area_floor(idx);
                    hi  = area_floor(idx + 1) - 1;
                    case ($urandom_range(0, 7))
                        0:       addr = ADDR_W'(lo);
                        1:       addr = ADDR_W'(hi);
                        default: addr = ADDR_W'($urandom_range(lo, hi));
                    endcase
                    op = op_t'($urandom_range(0, 1));
                end
                else
                begin
                    addr = ADDR_W'($urandom);
                    op   = op_t'($urandom_range(0, 1));
                end
                queue_access(op, addr, DATA_W'($urandom));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0 && map_expect.size() == 0)
            $display("bank_controller_address_map_tb: clean");
        else
            $display("bank_controller_address_map_tb: errors");
        $finish;
    end

endmodule
